[rtl/core/cbfm_pkg.sv]
// shared types, constants and codes for the clock buffer frame manager
package cbfm_pkg;

  localparam int NUM_FRAMES_DEF = 32;
  localparam int PIN_COUNT_MAX_DEF = 255;
  localparam int FRAME_W = 5;
  localparam int PIN_W = 8;

  localparam logic [2:0] ACT_READ = 3'd0;
  localparam logic [2:0] ACT_ALLOC = 3'd1;
  localparam logic [2:0] ACT_UNPIN = 3'd2;
  localparam logic [2:0] ACT_DISPOSE = 3'd3;
  localparam logic [2:0] ACT_FLUSH = 3'd4;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_EXCEEDED = 3'd1;
  localparam logic [2:0] ST_NOTPINNED = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_PINNED = 3'd4;
  localparam logic [2:0] ST_BADBUF = 3'd5;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] file_id;
    logic [23:0] page_no;
    logic mark_dirty;
  } req_t;

  typedef struct packed {
    logic kind;
    logic [2:0] status;
    logic [4:0] frame;
    logic [7:0] out_file_id;
    logic [23:0] out_page_no;
    logic fetch;
    logic last;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // capture request, clear scan index, save hand start
    logic step_idx;   // advance scan index
    logic step_hand;  // advance clock hand
    logic set_found;  // remember scan index as the hit frame
    logic clr_ref;    // clear reference bit at hand
    logic hit_touch;  // ref=1, pins+1 at found frame
    logic install;    // install page at hand
    logic unpin;      // unpin found frame
    logic clr_found;  // clear found frame
    logic clr_idx;    // clear frame at scan index
    logic hand_back;  // restore hand to start value
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic idx_last;     // scan index is the last frame
    logic idx_match;    // frame at index valid and matches file and page
    logic idx_file;     // frame at index valid and of file
    logic idx_pinned;   // frame at index pinned
    logic idx_dirty;    // frame at index dirty
    logic hand_valid;   // frame after hand valid
    logic hand_ref;
    logic hand_pinned;
    logic hand_dirty;
    logic found_pinned;
  } sts_t;

endpackage

[rtl/core/cbfm_datapath.sv]
// frame descriptor table, clock hand, scan index and request registers
module cbfm_datapath #(
  parameter int NUM_FRAMES = cbfm_pkg::NUM_FRAMES_DEF,
  parameter int PIN_COUNT_MAX = cbfm_pkg::PIN_COUNT_MAX_DEF
) (
  input  logic clk,
  input  logic rst,
  input  cbfm_pkg::req_t req,
  input  cbfm_pkg::cmd_t cmd,
  output cbfm_pkg::sts_t sts,
  output cbfm_pkg::req_t cur,
  output logic [cbfm_pkg::FRAME_W-1:0] hand_nx,
  output logic [cbfm_pkg::FRAME_W-1:0] idx,
  output logic [cbfm_pkg::FRAME_W-1:0] found,
  output logic [7:0] idx_file_q,
  output logic [23:0] idx_page_q,
  output logic [7:0] hand_file_q,
  output logic [23:0] hand_page_q
);
  localparam int FW = cbfm_pkg::FRAME_W;
  localparam int PW = cbfm_pkg::PIN_W;
  localparam logic [FW-1:0] LAST = FW'(NUM_FRAMES - 1);
  localparam logic [PW-1:0] PMAX = PW'(PIN_COUNT_MAX);

  logic [NUM_FRAMES-1:0] fvalid, fdirty, fref;
  logic [PW-1:0] fpins [NUM_FRAMES];
  logic [7:0] ffile [NUM_FRAMES];
  logic [23:0] fpage [NUM_FRAMES];
  logic [FW-1:0] hand, hand_start;

  // next frame after the clock hand
  assign hand_nx = (hand == LAST) ? '0 : hand + 1'b1;

  assign idx_file_q = ffile[idx];
  assign idx_page_q = fpage[idx];
  assign hand_file_q = ffile[hand_nx];
  assign hand_page_q = fpage[hand_nx];

  // status toward the controller
  always_comb begin
    sts.idx_last = (idx == LAST);
    sts.idx_file = fvalid[idx] && (ffile[idx] == cur.file_id);
    sts.idx_match = sts.idx_file && (fpage[idx] == cur.page_no);
    sts.idx_pinned = (fpins[idx] != '0);
    sts.idx_dirty = fdirty[idx];
    sts.hand_valid = fvalid[hand_nx];
    sts.hand_ref = fref[hand_nx];
    sts.hand_pinned = (fpins[hand_nx] != '0);
    sts.hand_dirty = fdirty[hand_nx];
    sts.found_pinned = (fpins[found] != '0);
  end

  // request, index, found and hand registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hand <= LAST;
      hand_start <= LAST;
      idx <= '0;
      found <= '0;
    end else begin
      if (cmd.load) begin
        cur <= req;
        idx <= '0;
        hand_start <= hand;
      end else if (cmd.step_idx) begin
        idx <= idx + 1'b1;
      end
      if (cmd.set_found) found <= idx;
      if (cmd.hand_back) hand <= hand_start;
      else if (cmd.step_hand) hand <= hand_nx;
      if (cmd.install) found <= hand_nx;
    end
  end

  // descriptor table updates
  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= '0;
      fdirty <= '0;
      fref <= '0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        fpins[i] <= '0;
        ffile[i] <= '0;
        fpage[i] <= '0;
      end
    end else begin
      if (cmd.clr_ref) fref[hand_nx] <= 1'b0;
      if (cmd.install) begin
        fvalid[hand_nx] <= 1'b1;
        fdirty[hand_nx] <= 1'b0;
        fref[hand_nx] <= 1'b1;
        fpins[hand_nx] <= PW'(1);
        ffile[hand_nx] <= cur.file_id;
        fpage[hand_nx] <= cur.page_no;
      end
      if (cmd.hit_touch) begin
        fref[found] <= 1'b1;
        if (fpins[found] < PMAX) fpins[found] <= fpins[found] + 1'b1;
      end
      if (cmd.unpin) begin
        if (cur.mark_dirty) fdirty[found] <= 1'b1;
        fpins[found] <= fpins[found] - 1'b1;
      end
      if (cmd.clr_found) begin
        fvalid[found] <= 1'b0;
        fdirty[found] <= 1'b0;
        fref[found] <= 1'b0;
        fpins[found] <= '0;
        ffile[found] <= '0;
        fpage[found] <= '0;
      end
      if (cmd.clr_idx) begin
        fvalid[idx] <= 1'b0;
        fdirty[idx] <= 1'b0;
        fref[idx] <= 1'b0;
        fpins[idx] <= '0;
        ffile[idx] <= '0;
        fpage[idx] <= '0;
      end
    end
  end
endmodule

[rtl/core/cbfm_ctrl.sv]
// controller: lookup scan, clock sweep, flush walk and result output register
module cbfm_ctrl #(
  parameter int NUM_FRAMES = cbfm_pkg::NUM_FRAMES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cbfm_pkg::rsp_t rsp,
  output cbfm_pkg::cmd_t cmd,
  input  cbfm_pkg::sts_t sts,
  input  cbfm_pkg::req_t cur,
  input  logic [cbfm_pkg::FRAME_W-1:0] hand_nx,
  input  logic [cbfm_pkg::FRAME_W-1:0] idx,
  input  logic [cbfm_pkg::FRAME_W-1:0] found,
  input  logic [7:0] idx_file_q,
  input  logic [23:0] idx_page_q,
  input  logic [7:0] hand_file_q,
  input  logic [23:0] hand_page_q
);
  localparam int FW = cbfm_pkg::FRAME_W;
  localparam int SW = $clog2(2 * NUM_FRAMES + 1);
  localparam logic [SW-1:0] SWEEP_N = SW'(2 * NUM_FRAMES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_LOOK = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;
  localparam logic [2:0] S_FIN = 3'd6;

  logic [2:0] state, state_next;
  logic [SW-1:0] steps;
  logic hit;
  logic out_free;
  logic emit;
  cbfm_pkg::rsp_t emit_rsp;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // result constructors
  function automatic cbfm_pkg::rsp_t fin(logic [2:0] st, logic [FW-1:0] fr, logic fe);
    cbfm_pkg::rsp_t r;
    r = '0;
    r.status = st;
    r.frame = fr;
    r.fetch = fe;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic cbfm_pkg::rsp_t wb(logic [FW-1:0] fr, logic [7:0] fl, logic [23:0] pg);
    cbfm_pkg::rsp_t r;
    r = '0;
    r.kind = 1'b1;
    r.frame = fr;
    r.out_file_id = fl;
    r.out_page_no = pg;
    return r;
  endfunction

  // sequencing of one request
  always_comb begin
    cmd = '0;
    state_next = state;
    emit = 1'b0;
    emit_rsp = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (cur.action)
          cbfm_pkg::ACT_READ, cbfm_pkg::ACT_UNPIN, cbfm_pkg::ACT_DISPOSE:
            state_next = S_LOOK;
          cbfm_pkg::ACT_ALLOC: state_next = S_SWEEP;
          cbfm_pkg::ACT_FLUSH: state_next = S_FLUSH;
          default: begin
            // unknown action: table untouched
            if (out_free) begin
              emit = 1'b1;
              emit_rsp = fin(cbfm_pkg::ST_BADBUF, '0, 1'b0);
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_LOOK: begin
        if (sts.idx_match && !hit) cmd.set_found = 1'b1;
        if (sts.idx_last) begin
          // lookup done: act on hit frame
          if (hit || sts.idx_match) state_next = S_OUT;
          else if (cur.action == cbfm_pkg::ACT_READ) state_next = S_SWEEP;
          else if (out_free) begin
            emit = 1'b1;
            emit_rsp = fin((cur.action == cbfm_pkg::ACT_UNPIN) ?
                           cbfm_pkg::ST_NOTFOUND : cbfm_pkg::ST_OK, '0, 1'b0);
            state_next = S_IDLE;
          end
        end else begin
          cmd.step_idx = 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          emit = 1'b1;
          state_next = S_IDLE;
          case (cur.action)
            cbfm_pkg::ACT_READ: begin
              cmd.hit_touch = 1'b1;
              emit_rsp = fin(cbfm_pkg::ST_OK, found, 1'b0);
            end
            cbfm_pkg::ACT_UNPIN: begin
              if (sts.found_pinned) begin
                cmd.unpin = 1'b1;
                emit_rsp = fin(cbfm_pkg::ST_OK, '0, 1'b0);
              end else begin
                emit_rsp = fin(cbfm_pkg::ST_NOTPINNED, '0, 1'b0);
              end
            end
            default: begin
              cmd.clr_found = 1'b1;
              emit_rsp = fin(cbfm_pkg::ST_OK, '0, 1'b0);
            end
          endcase
        end
      end
      S_SWEEP: begin
        if (out_free) begin
          if (steps == SWEEP_N) begin
            cmd.hand_back = 1'b1;
            emit = 1'b1;
            emit_rsp = fin(cbfm_pkg::ST_EXCEEDED, '0, 1'b0);
            state_next = S_IDLE;
          end else if (!sts.hand_valid) begin
            cmd.step_hand = 1'b1;
            cmd.install = 1'b1;
            emit = 1'b1;
            emit_rsp = fin(cbfm_pkg::ST_OK, hand_nx, cur.action == cbfm_pkg::ACT_READ);
            state_next = S_IDLE;
          end else if (sts.hand_ref) begin
            cmd.step_hand = 1'b1;
            cmd.clr_ref = 1'b1;
          end else if (sts.hand_pinned) begin
            cmd.step_hand = 1'b1;
          end else begin
            // evict: install overwrites all descriptor fields
            cmd.step_hand = 1'b1;
            cmd.install = 1'b1;
            emit = 1'b1;
            if (sts.hand_dirty) begin
              // writeback now, final result from S_FIN once the output is free
              emit_rsp = wb(hand_nx, hand_file_q, hand_page_q);
              state_next = S_FIN;
            end else begin
              emit_rsp = fin(cbfm_pkg::ST_OK, hand_nx, cur.action == cbfm_pkg::ACT_READ);
              state_next = S_IDLE;
            end
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          if (sts.idx_file && sts.idx_pinned) begin
            emit = 1'b1;
            emit_rsp = fin(cbfm_pkg::ST_PINNED, '0, 1'b0);
            state_next = S_IDLE;
          end else begin
            if (sts.idx_file) begin
              cmd.clr_idx = 1'b1;
              if (sts.idx_dirty) begin
                emit = 1'b1;
                emit_rsp = wb(idx, idx_file_q, idx_page_q);
              end
            end
            if (sts.idx_last) begin
              state_next = S_FIN;
            end else begin
              cmd.step_idx = 1'b1;
            end
          end
        end
      end
      S_FIN: begin
        // final ok after a flush walk or a dirty eviction
        if (out_free) begin
          emit = 1'b1;
          emit_rsp = fin(cbfm_pkg::ST_OK, (cur.action == cbfm_pkg::ACT_FLUSH) ? '0 : found,
                         cur.action == cbfm_pkg::ACT_READ);
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      rsp <= '0;
      steps <= '0;
      hit <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
        rsp <= emit_rsp;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) steps <= '0;
      else if (state == S_SWEEP && cmd.step_hand && !cmd.install) steps <= steps + 1'b1;
      if (cmd.load) hit <= 1'b0;
      else if (cmd.set_found) hit <= 1'b1;
    end
  end
endmodule

[rtl/core/clock_buffer_frame_manager_core.sv]
// top level of the clock buffer frame manager
//   channel | direction | handshake         | payload
//   req     | in        | req_valid/stall   | cbfm_pkg::req_t
//   rsp     | out       | rsp_valid/stall   | cbfm_pkg::rsp_t
// one request at a time; req_stall is high from acceptance until the final result
// is registered. the lookup scan checks one frame per cycle; the clock sweep gives
// up with ST_EXCEEDED after 2*NUM_FRAMES hand steps that install nothing, and a
// dirty victim or a flush walk ends with a final result from the S_FIN state.
// reset clears all descriptors and puts the hand at the last frame.
// a stalled result holds the controller wherever it has a result to give.
module clock_buffer_frame_manager_core #(
  parameter int NUM_FRAMES = cbfm_pkg::NUM_FRAMES_DEF,
  parameter int PIN_COUNT_MAX = cbfm_pkg::PIN_COUNT_MAX_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  cbfm_pkg::req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output cbfm_pkg::rsp_t rsp
);
  cbfm_pkg::cmd_t cmd;
  cbfm_pkg::sts_t sts;
  cbfm_pkg::req_t cur;
  logic [cbfm_pkg::FRAME_W-1:0] hand_nx, idx, found;
  logic [7:0] idx_file_q, hand_file_q;
  logic [23:0] idx_page_q, hand_page_q;

  cbfm_ctrl #(.NUM_FRAMES(NUM_FRAMES)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(req_valid), .in_stall(req_stall),
    .out_valid(rsp_valid), .out_stall(rsp_stall), .rsp(rsp), .cmd(cmd), .sts(sts),
    .cur(cur), .hand_nx(hand_nx), .idx(idx), .found(found),
    .idx_file_q(idx_file_q), .idx_page_q(idx_page_q),
    .hand_file_q(hand_file_q), .hand_page_q(hand_page_q)
  );

  cbfm_datapath #(.NUM_FRAMES(NUM_FRAMES), .PIN_COUNT_MAX(PIN_COUNT_MAX)) u_dp (
    .clk(clk), .rst(rst), .req(req), .cmd(cmd), .sts(sts), .cur(cur),
    .hand_nx(hand_nx), .idx(idx), .found(found),
    .idx_file_q(idx_file_q), .idx_page_q(idx_page_q),
    .hand_file_q(hand_file_q), .hand_page_q(hand_page_q)
  );
endmodule

[rtl/core/cbfm_checker.sv]
// port-level checks for the frame manager, bound to the top level
module cbfm_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input cbfm_pkg::rsp_t rsp
);
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp)) else $error("rsp changed");
  // a writeback is never the final result
  a_wb: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind |-> !rsp.last) else $error("wb last");
  // a request is taken only while idle: after accept, busy next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall) else $error("not busy");
  // writebacks carry ok status
  a_wbst: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind |-> rsp.status == cbfm_pkg::ST_OK) else $error("wb status");
endmodule

bind clock_buffer_frame_manager_core cbfm_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
  .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
);
